FILE: rtl/ccix_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_pkg: shared constants and types for the circle intersection block
// Widths of every intermediate value follow from the coordinate and fraction
// widths, together with the status codes and the buses between the parts.
// ---------------------------------------------------------------------------
package ccix_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 40;

    // Center difference, squared radius, squared distance, power term.
    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS;
    localparam int QW  = 2 * COORD_BITS + 1;
    localparam int EW  = 2 * COORD_BITS + 3;
    // Discriminant: signed width and width of its nonnegative values.
    localparam int NW  = 4 * COORD_BITS + 5;
    localparam int NPW = 4 * COORD_BITS + 3;
    // Scaled square root, radicand and partial remainder.
    localparam int SW   = 2 * COORD_BITS + FRAC_BITS + 2;
    localparam int RADW = 2 * SW;
    localparam int RMW  = SW + 3;
    // Numerator of the offset division, divisor and scaled center.
    localparam int MW  = 3 * COORD_BITS + FRAC_BITS + 5;
    localparam int DVW = QW + 1;
    localparam int PW  = COORD_BITS + FRAC_BITS;
    // Width of a point before saturation.
    localparam int VW  = (MW + 2 > OUT_BITS) ? MW + 2 : OUT_BITS + 1;

    localparam int LANES  = 4;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_SAME = 2'd2
    } t_status;

    // Values that travel with an item from the front part to the divider.
    typedef struct packed {
        t_status                      status;
        logic signed [EW-1:0]         e;
        logic signed [DW-1:0]         ddx;
        logic signed [DW-1:0]         ddy;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic [QW-1:0]                q;
    } t_side;

    // One classified item as held in the queue.
    typedef struct packed {
        t_side          side;
        logic [NPW-1:0] n;
    } t_job;

    typedef struct packed {
        logic            valid;
        logic [RADW-1:0] rad;
        t_side           side;
    } t_sq_bus;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] root;
        t_side         side;
    } t_sq_res;

    typedef struct packed {
        logic                        valid;
        logic [LANES-1:0][MW-1:0]    mag;
        logic [LANES-1:0]            neg;
        logic [DVW-1:0]              d;
        logic signed [PW-1:0]        bx;
        logic signed [PW-1:0]        by;
        t_status                     status;
    } t_dv_bus;

    typedef struct packed {
        logic                        valid;
        logic [LANES-1:0][MW-1:0]    quo;
        logic [LANES-1:0]            neg;
        logic signed [PW-1:0]        bx;
        logic signed [PW-1:0]        by;
        t_status                     status;
    } t_dv_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: rtl/ccix_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_if: item channels of the circle intersection block
// The input channel carries a pair of circles, the output channel the two
// crossing points and a status, each with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface ccix_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ccix_pkg::COORD_BITS-1:0] first_center_x;
    logic signed [ccix_pkg::COORD_BITS-1:0] first_center_y;
    logic [ccix_pkg::COORD_BITS-1:0]        first_radius;
    logic signed [ccix_pkg::COORD_BITS-1:0] second_center_x;
    logic signed [ccix_pkg::COORD_BITS-1:0] second_center_y;
    logic [ccix_pkg::COORD_BITS-1:0]        second_radius;

    modport source (
        output valid, first_center_x, first_center_y, first_radius,
               second_center_x, second_center_y, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_center_x, first_center_y, first_radius,
               second_center_x, second_center_y, second_radius,
        output ready
    );
endinterface

interface ccix_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ccix_pkg::OUT_BITS-1:0] point_one_x;
    logic signed [ccix_pkg::OUT_BITS-1:0] point_one_y;
    logic signed [ccix_pkg::OUT_BITS-1:0] point_two_x;
    logic signed [ccix_pkg::OUT_BITS-1:0] point_two_y;
    ccix_pkg::t_status                    status;

    modport source (
        output valid, point_one_x, point_one_y, point_two_x, point_two_y, status,
        input  ready
    );
    modport sink (
        input  valid, point_one_x, point_one_y, point_two_x, point_two_y, status,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/ccix_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_front: item intake and classification
// A four-stage pipeline forms the center difference, the squared distance,
// the power term and the discriminant, then sorts each item by status.
// ---------------------------------------------------------------------------
module ccix_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ccix_in_if.sink        i_in,
    input  logic           i_room,
    output logic           o_push,
    output ccix_pkg::t_job o_job
);

    logic [3:0] r_v;
    logic       adv;

    // Stage one: differences and squared radii.
    logic signed [ccix_pkg::DW-1:0]         r1_ddx, r1_ddy;
    logic signed [ccix_pkg::COORD_BITS-1:0] r1_x1, r1_y1;
    logic [ccix_pkg::SQW-1:0]               r1_r1sq, r1_r2sq;
    // Stage two: squared differences.
    logic signed [2*ccix_pkg::DW-1:0]       sq_dx, sq_dy;
    logic [ccix_pkg::SQW-1:0]               r2_dx2, r2_dy2;
    logic signed [ccix_pkg::DW-1:0]         r2_ddx, r2_ddy;
    logic signed [ccix_pkg::COORD_BITS-1:0] r2_x1, r2_y1;
    logic [ccix_pkg::SQW-1:0]               r2_r1sq, r2_r2sq;
    // Stage three: squared distance and power term.
    logic [ccix_pkg::QW-1:0]                n_q;
    logic signed [ccix_pkg::EW-1:0]         n_e;
    logic [ccix_pkg::QW-1:0]                r3_q;
    logic signed [ccix_pkg::EW-1:0]         r3_e;
    logic signed [ccix_pkg::DW-1:0]         r3_ddx, r3_ddy;
    logic signed [ccix_pkg::COORD_BITS-1:0] r3_x1, r3_y1;
    logic [ccix_pkg::SQW-1:0]               r3_r1sq;
    // Stage four: the two products of the discriminant.
    logic [ccix_pkg::QW+ccix_pkg::SQW-1:0]  qr;
    logic signed [2*ccix_pkg::EW-1:0]       esq;
    logic [ccix_pkg::NPW-1:0]               r4_a;
    logic [ccix_pkg::NPW:0]                 r4_esq;
    ccix_pkg::t_side                        r4_side;
    // Discriminant.
    logic signed [ccix_pkg::NW-1:0]         n_n;

    // The pipeline moves whenever the queue has a free slot.
    assign adv        = i_room;
    assign i_in.ready = adv;
    assign o_push     = r_v[3] && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_in.valid};
        end
    end

    assign sq_dx = r1_ddx * r1_ddx;
    assign sq_dy = r1_ddy * r1_ddy;
    assign n_q   = {1'b0, r2_dx2} + {1'b0, r2_dy2};
    assign n_e   = $signed(ccix_pkg::EW'(n_q)) + $signed(ccix_pkg::EW'(r2_r1sq))
                 - $signed(ccix_pkg::EW'(r2_r2sq));
    assign qr    = r3_q * r3_r1sq;
    assign esq   = r3_e * r3_e;

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ddx  <= ccix_pkg::DW'(i_in.second_center_x) - ccix_pkg::DW'(i_in.first_center_x);
            r1_ddy  <= ccix_pkg::DW'(i_in.second_center_y) - ccix_pkg::DW'(i_in.first_center_y);
            r1_x1   <= i_in.first_center_x;
            r1_y1   <= i_in.first_center_y;
            r1_r1sq <= i_in.first_radius * i_in.first_radius;
            r1_r2sq <= i_in.second_radius * i_in.second_radius;

            r2_dx2  <= sq_dx[ccix_pkg::SQW-1:0];
            r2_dy2  <= sq_dy[ccix_pkg::SQW-1:0];
            r2_ddx  <= r1_ddx;
            r2_ddy  <= r1_ddy;
            r2_x1   <= r1_x1;
            r2_y1   <= r1_y1;
            r2_r1sq <= r1_r1sq;
            r2_r2sq <= r1_r2sq;

            r3_q    <= n_q;
            r3_e    <= n_e;
            r3_ddx  <= r2_ddx;
            r3_ddy  <= r2_ddy;
            r3_x1   <= r2_x1;
            r3_y1   <= r2_y1;
            r3_r1sq <= r2_r1sq;

            r4_a           <= {qr, 2'b00};
            r4_esq         <= esq[ccix_pkg::NPW:0];
            r4_side.status <= ccix_pkg::ST_OK;
            r4_side.e      <= r3_e;
            r4_side.ddx    <= r3_ddx;
            r4_side.ddy    <= r3_ddy;
            r4_side.x1     <= r3_x1;
            r4_side.y1     <= r3_y1;
            r4_side.q      <= r3_q;
        end
    end

    // Classify: equal centers first, then a negative discriminant.
    assign n_n = $signed({2'b00, r4_a}) - $signed({1'b0, r4_esq});

    always_comb begin
        o_job             = '0;
        o_job.side        = r4_side;
        o_job.n           = n_n[ccix_pkg::NPW-1:0];
        if (r4_side.q == '0) begin
            o_job.side.status = ccix_pkg::ST_SAME;
        end else if (n_n[ccix_pkg::NW-1]) begin
            o_job.side.status = ccix_pkg::ST_NONE;
        end else begin
            o_job.side.status = ccix_pkg::ST_OK;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ccix_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_queue: short queue of classified items
// Decouples the front part from the back part so that each stalls alone.
// ---------------------------------------------------------------------------
module ccix_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ccix_pkg::t_job    i_job,
    input  logic              i_pop,
    output logic              o_valid,
    output ccix_pkg::t_job    o_job,
    output logic              o_room,
    output ccix_pkg::t_q_stat o_stat
);

    ccix_pkg::t_job            r_mem [ccix_pkg::QDEPTH];
    logic [ccix_pkg::QAW-1:0]  r_wr, r_rd;
    logic [ccix_pkg::QAW:0]    r_cnt;

    assign o_stat.full  = (r_cnt == (ccix_pkg::QAW + 1)'(ccix_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_room       = !o_stat.full;
    assign o_valid      = !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ccix_sqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_sqrt: pipelined integer square root
// One result bit per stage by the digit-by-digit method; side data rides
// along with each item.
// ---------------------------------------------------------------------------
module ccix_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ccix_pkg::t_sq_bus i_bus,
    output ccix_pkg::t_sq_res o_res
);

    typedef struct packed {
        logic [ccix_pkg::RADW-1:0] rad;
        logic [ccix_pkg::RMW-1:0]  rem;
        logic [ccix_pkg::SW-1:0]   root;
        ccix_pkg::t_side           side;
    } t_sq_stage;

    logic [ccix_pkg::SW:0] r_vld;
    t_sq_stage             r_pl [ccix_pkg::SW+1];
    t_sq_stage             n_pl [ccix_pkg::SW+1];

    // One root digit from the top two radicand bits.
    function automatic t_sq_stage sq_step(input t_sq_stage s);
        t_sq_stage              res;
        logic [ccix_pkg::RMW-1:0] rem2;
        logic [ccix_pkg::RMW-1:0] trial;
        res   = s;
        rem2  = {s.rem[ccix_pkg::RMW-3:0], s.rad[ccix_pkg::RADW-1:ccix_pkg::RADW-2]};
        trial = ccix_pkg::RMW'({s.root, 2'b01});
        res.rad = {s.rad[ccix_pkg::RADW-3:0], 2'b00};
        if (rem2 >= trial) begin
            res.rem  = rem2 - trial;
            res.root = {s.root[ccix_pkg::SW-2:0], 1'b1};
        end else begin
            res.rem  = rem2;
            res.root = {s.root[ccix_pkg::SW-2:0], 1'b0};
        end
        return res;
    endfunction

    always_comb begin
        n_pl[0].rad  = i_bus.rad;
        n_pl[0].rem  = '0;
        n_pl[0].root = '0;
        n_pl[0].side = i_bus.side;
        for (int k = 0; k < ccix_pkg::SW; k++) begin
            n_pl[k+1] = sq_step(r_pl[k]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ccix_pkg::SW-1:0], i_bus.valid};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= ccix_pkg::SW; k++) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    assign o_res.valid = r_vld[ccix_pkg::SW];
    assign o_res.root  = r_pl[ccix_pkg::SW].root;
    assign o_res.side  = r_pl[ccix_pkg::SW].side;

endmodule
`default_nettype wire

FILE: rtl/ccix_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_div: pipelined four-lane restoring divider
// Four magnitudes share one divisor; each stage produces one quotient bit
// per lane.
// ---------------------------------------------------------------------------
module ccix_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ccix_pkg::t_dv_bus i_bus,
    output ccix_pkg::t_dv_res o_res
);

    typedef struct packed {
        logic [ccix_pkg::LANES-1:0][ccix_pkg::DVW+ccix_pkg::MW-1:0] rq;
        logic [ccix_pkg::LANES-1:0]                                 neg;
        logic [ccix_pkg::DVW-1:0]                                   d;
        logic signed [ccix_pkg::PW-1:0]                             bx;
        logic signed [ccix_pkg::PW-1:0]                             by;
        ccix_pkg::t_status                                          status;
    } t_dv_stage;

    logic [ccix_pkg::MW:0] r_vld;
    t_dv_stage             r_pl [ccix_pkg::MW+1];
    t_dv_stage             n_pl [ccix_pkg::MW+1];

    // Shift in the next dividend bit and subtract the divisor if it fits.
    function automatic logic [ccix_pkg::DVW+ccix_pkg::MW-1:0] div_step(
        input logic [ccix_pkg::DVW+ccix_pkg::MW-1:0] rq,
        input logic [ccix_pkg::DVW-1:0]              d
    );
        logic [ccix_pkg::DVW:0] top;
        logic                   qbit;
        top  = rq[ccix_pkg::DVW+ccix_pkg::MW-1:ccix_pkg::MW-1];
        qbit = (top >= {1'b0, d});
        if (qbit) begin
            top = top - {1'b0, d};
        end
        return {top[ccix_pkg::DVW-1:0], rq[ccix_pkg::MW-2:0], qbit};
    endfunction

    always_comb begin
        for (int l = 0; l < ccix_pkg::LANES; l++) begin
            n_pl[0].rq[l] = {{ccix_pkg::DVW{1'b0}}, i_bus.mag[l]};
        end
        n_pl[0].neg    = i_bus.neg;
        n_pl[0].d      = i_bus.d;
        n_pl[0].bx     = i_bus.bx;
        n_pl[0].by     = i_bus.by;
        n_pl[0].status = i_bus.status;
        for (int k = 0; k < ccix_pkg::MW; k++) begin
            n_pl[k+1] = r_pl[k];
            for (int l = 0; l < ccix_pkg::LANES; l++) begin
                n_pl[k+1].rq[l] = div_step(r_pl[k].rq[l], r_pl[k].d);
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ccix_pkg::MW-1:0], i_bus.valid};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= ccix_pkg::MW; k++) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    always_comb begin
        o_res.valid = r_vld[ccix_pkg::MW];
        for (int l = 0; l < ccix_pkg::LANES; l++) begin
            o_res.quo[l] = r_pl[ccix_pkg::MW].rq[l][ccix_pkg::MW-1:0];
        end
        o_res.neg    = r_pl[ccix_pkg::MW].neg;
        o_res.bx     = r_pl[ccix_pkg::MW].bx;
        o_res.by     = r_pl[ccix_pkg::MW].by;
        o_res.status = r_pl[ccix_pkg::MW].status;
    end

endmodule
`default_nettype wire

FILE: rtl/ccix_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ccix_back: root, offsets, division and output register
// Takes classified items from the queue, forms the four offset numerators,
// divides them by twice the squared distance and saturates the points.
// ---------------------------------------------------------------------------
module ccix_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  ccix_pkg::t_job i_job,
    output logic           o_pop,
    ccix_out_if.source     o_out
);

    logic              adv;
    ccix_pkg::t_sq_bus sq_bus;
    ccix_pkg::t_sq_res sq_res;
    ccix_pkg::t_dv_bus dv_bus;
    ccix_pkg::t_dv_res dv_res;

    // Products stage.
    logic                                         r_m1_v;
    logic signed [ccix_pkg::EW+ccix_pkg::DW-1:0]  n_pex, n_pey, r_pex, r_pey;
    logic signed [ccix_pkg::SW+ccix_pkg::DW:0]    n_psx, n_psy, r_psx, r_psy;
    ccix_pkg::t_side                              r_m1_side;
    // Numerator stage.
    logic                                         r_m2_v;
    logic signed [ccix_pkg::MW-1:0]               ex, ey, psx, psy, qq;
    logic [ccix_pkg::LANES-1:0][ccix_pkg::MW-1:0] n_num, r_num;
    ccix_pkg::t_side                              r_m2_side;
    // Output stage.
    logic signed [ccix_pkg::MW:0]                 qs [ccix_pkg::LANES];
    logic signed [ccix_pkg::VW-1:0]               sv [ccix_pkg::LANES];
    logic [ccix_pkg::LANES-1:0][ccix_pkg::OUT_BITS-1:0] n_pt, r_pt;
    logic                                         r_out_valid;
    ccix_pkg::t_status                            r_status;

    function automatic logic [ccix_pkg::OUT_BITS-1:0] sat_out(
        input logic signed [ccix_pkg::VW-1:0] v
    );
        logic [ccix_pkg::OUT_BITS-1:0] res;
        if (v > ccix_pkg::VW'(ccix_pkg::OUT_MAX)) begin
            res = ccix_pkg::OUT_MAX;
        end else if (v < ccix_pkg::VW'(ccix_pkg::OUT_MIN)) begin
            res = ccix_pkg::OUT_MIN;
        end else begin
            res = v[ccix_pkg::OUT_BITS-1:0];
        end
        return res;
    endfunction

    // The whole back pipeline moves when the output register can take an item.
    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && i_job_valid;

    // Radicand is the discriminant scaled by the square of the fraction; it is zero for an item without status OK.
    always_comb begin
        sq_bus.valid = i_job_valid;
        sq_bus.side  = i_job.side;
        if (i_job.side.status == ccix_pkg::ST_OK) begin
            sq_bus.rad = {{(ccix_pkg::RADW - ccix_pkg::NPW - 2 * ccix_pkg::FRAC_BITS){1'b0}},
                          i_job.n, {(2 * ccix_pkg::FRAC_BITS){1'b0}}};
        end else begin
            sq_bus.rad = '0;
        end
    end

    ccix_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_bus   (sq_bus),
        .o_res   (sq_res)
    );

    assign n_pex = sq_res.side.e * sq_res.side.ddx;
    assign n_pey = sq_res.side.e * sq_res.side.ddy;
    assign n_psx = $signed({1'b0, sq_res.root}) * sq_res.side.ddx;
    assign n_psy = $signed({1'b0, sq_res.root}) * sq_res.side.ddy;

    // Numerators with the rounding half-divisor already added.
    assign ex  = ccix_pkg::MW'(r_pex) <<< ccix_pkg::FRAC_BITS;
    assign ey  = ccix_pkg::MW'(r_pey) <<< ccix_pkg::FRAC_BITS;
    assign psx = ccix_pkg::MW'(r_psx);
    assign psy = ccix_pkg::MW'(r_psy);
    assign qq  = $signed(ccix_pkg::MW'(r_m1_side.q));

    assign n_num[0] = ex + psy + qq;
    assign n_num[1] = ey - psx + qq;
    assign n_num[2] = ex - psy + qq;
    assign n_num[3] = ey + psx + qq;

    // Valid bits of the local stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v      <= 1'b0;
            r_m2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_m1_v      <= sq_res.valid;
            r_m2_v      <= r_m1_v;
            r_out_valid <= dv_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pex     <= n_pex;
            r_pey     <= n_pey;
            r_psx     <= n_psx;
            r_psy     <= n_psy;
            r_m1_side <= sq_res.side;
            r_num     <= n_num;
            r_m2_side <= r_m1_side;
            r_pt      <= n_pt;
            r_status  <= dv_res.status;
        end
    end

    // Floor division on magnitudes: a negative numerator is biased so the
    // quotient of its magnitude rounds up.
    always_comb begin
        dv_bus.valid  = r_m2_v;
        dv_bus.d      = {r_m2_side.q, 1'b0};
        dv_bus.bx     = {r_m2_side.x1, {ccix_pkg::FRAC_BITS{1'b0}}};
        dv_bus.by     = {r_m2_side.y1, {ccix_pkg::FRAC_BITS{1'b0}}};
        dv_bus.status = r_m2_side.status;
        for (int l = 0; l < ccix_pkg::LANES; l++) begin
            dv_bus.neg[l] = r_num[l][ccix_pkg::MW-1];
            if (r_num[l][ccix_pkg::MW-1]) begin
                dv_bus.mag[l] = ~r_num[l] + ccix_pkg::MW'({r_m2_side.q, 1'b0});
            end else begin
                dv_bus.mag[l] = r_num[l];
            end
        end
    end

    ccix_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_bus   (dv_bus),
        .o_res   (dv_res)
    );

    // Restore the sign, add the first center and saturate; an item without status OK gets zero points.
    always_comb begin
        for (int l = 0; l < ccix_pkg::LANES; l++) begin
            if (dv_res.neg[l]) begin
                qs[l] = -$signed({1'b0, dv_res.quo[l]});
            end else begin
                qs[l] = $signed({1'b0, dv_res.quo[l]});
            end
            if (l % 2 == 0) begin
                sv[l] = ccix_pkg::VW'(qs[l]) + ccix_pkg::VW'(dv_res.bx);
            end else begin
                sv[l] = ccix_pkg::VW'(qs[l]) + ccix_pkg::VW'(dv_res.by);
            end
            if (dv_res.status == ccix_pkg::ST_OK) begin
                n_pt[l] = sat_out(sv[l]);
            end else begin
                n_pt[l] = '0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_one_x = r_pt[0];
    assign o_out.point_one_y = r_pt[1];
    assign o_out.point_two_x = r_pt[2];
    assign o_out.point_two_y = r_pt[3];
    assign o_out.status      = r_status;

endmodule
`default_nettype wire

FILE: rtl/circle_circle_intersection.sv
`default_nettype none
// ---------------------------------------------------------------------------
// circle_circle_intersection: crossing points of two integer circles
// Accepts one pair of circles per cycle while its queue has room and returns both crossing points in
// signed Q.16 fixed point with a status.
// ---------------------------------------------------------------------------
// The block takes a new pair of circles every cycle and delivers one result
// per cycle while the output side keeps taking them. Each item passes the
// front stages, the queue, the bit-per-stage square root (SW stages), the
// products and numerator stages, the bit-per-stage divider (MW stages) and
// the output register. A four-entry queue sits between the classifying
// front pipeline and the arithmetic back pipeline. Equal centers give status
// 2 and a negative discriminant status 1, both with all point fields zero;
// points outside the 40-bit range saturate.
module circle_circle_intersection (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccix_in_if.sink    i_in,
    ccix_out_if.source o_out
);

    logic              push;
    logic              pop;
    logic              room;
    logic              job_valid;
    ccix_pkg::t_job    front_job;
    ccix_pkg::t_job    back_job;
    ccix_pkg::t_q_stat q_stat;

    ccix_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push),
        .o_job   (front_job)
    );

    ccix_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (back_job),
        .o_room  (room),
        .o_stat  (q_stat)
    );

    ccix_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (back_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // An item pushed into an empty queue is there in the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.empty && push) |=> !q_stat.empty)
        else $error("queue lost a pushed item");

    // The back part never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // A failed item carries zero points.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ccix_pkg::ST_OK) |->
        (o_out.point_one_x == '0 && o_out.point_one_y == '0 &&
         o_out.point_two_x == '0 && o_out.point_two_y == '0))
        else $error("nonzero points with failure status");
`endif

endmodule
`default_nettype wire
